// ===== design/vbp_pkg.sv =====
// ----------------------------------------------------------------------------
// vbp_pkg: shared types and constants for the voxel box push-out unit
// Payload structs, register defaults, register indexes and width helpers.
// ----------------------------------------------------------------------------
package vbp_pkg;

  localparam int POS_W         = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int MARGIN_W      = 17;
  localparam int HEIGHT_W      = 19;
  localparam int SOLID_W       = 27;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;

  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(19661);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(98304);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EDGE_MARGIN = 1'b0,
    CFG_BODY_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [SOLID_W-1:0]      neighbor_solid;
  } body_t;

  typedef struct packed {
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [POS_W-1:0] new_z;
  } result_t;

  // Signed width of a box-bound offset from the floored cell base.
  function automatic int ext_w(input int frac);
    return (((frac + 2) > HEIGHT_W) ? (frac + 2) : HEIGHT_W) + 2;
  endfunction

  // Signed width of positions and box bounds between voxels.
  function automatic int pos_int_w(input int frac);
    return ((POS_W > ext_w(frac)) ? POS_W : ext_w(frac)) + 1;
  endfunction

endpackage

// ===== design/vbp_cell.sv =====
// ----------------------------------------------------------------------------
// vbp_cell: one voxel of the push-out chain
// Three stages: box bounds, face distances and hit test, nearest-face snap.
// ----------------------------------------------------------------------------
module vbp_cell #(
  parameter int FRAC_BITS = vbp_pkg::FRAC_BITS_DEF,
  parameter int DX        = 0,
  parameter int DY        = 0,
  parameter int DZ        = 0
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              en,
  input  logic [vbp_pkg::MARGIN_W-1:0]                      margin,
  input  logic [vbp_pkg::HEIGHT_W-1:0]                      height,
  input  logic                                              up_vld,
  input  logic signed [vbp_pkg::pos_int_w(FRAC_BITS)-1:0]   up_p [3],
  input  logic signed [vbp_pkg::pos_int_w(FRAC_BITS)-1:0]   up_base [3],
  input  logic [vbp_pkg::SOLID_W-1:0]                       up_solid,
  output logic                                              dn_vld,
  output logic signed [vbp_pkg::pos_int_w(FRAC_BITS)-1:0]   dn_p [3],
  output logic signed [vbp_pkg::pos_int_w(FRAC_BITS)-1:0]   dn_base [3],
  output logic [vbp_pkg::SOLID_W-1:0]                       dn_solid
);
  import vbp_pkg::*;

  localparam int EW     = ext_w(FRAC_BITS);
  localparam int PIW    = pos_int_w(FRAC_BITS);
  localparam int DIST_W = EW;
  localparam int IDX    = 9 * DX + 3 * DY + DZ;
  localparam int ONE_I  = 1 << FRAC_BITS;

  localparam logic signed [EW-1:0] LO_KX = EW'((DX - 1) * ONE_I);
  localparam logic signed [EW-1:0] HI_KX = EW'(DX * ONE_I);
  localparam logic signed [EW-1:0] LO_KY = EW'((DY - 2) * ONE_I);
  localparam logic signed [EW-1:0] HI_KY = EW'((DY - 1) * ONE_I);
  localparam logic signed [EW-1:0] LO_KZ = EW'((DZ - 1) * ONE_I);
  localparam logic signed [EW-1:0] HI_KZ = EW'(DZ * ONE_I);

  logic signed [EW-1:0]     m_s;
  logic signed [EW-1:0]     h_s;
  logic signed [EW-1:0]     lo_off [3];
  logic signed [EW-1:0]     hi_off [3];
  logic signed [PIW-1:0]    lo_next [3];
  logic signed [PIW-1:0]    hi_next [3];

  logic                     s1_vld;
  logic signed [PIW-1:0]    s1_p [3];
  logic signed [PIW-1:0]    s1_base [3];
  logic signed [PIW-1:0]    s1_lo [3];
  logic signed [PIW-1:0]    s1_hi [3];
  logic [SOLID_W-1:0]       s1_solid;

  logic signed [PIW:0]      dlo [3];
  logic signed [PIW:0]      dhi [3];
  logic [DIST_W-1:0]        d_next [6];
  logic                     hit_next;

  logic                     s2_vld;
  logic signed [PIW-1:0]    s2_p [3];
  logic signed [PIW-1:0]    s2_base [3];
  logic signed [PIW-1:0]    s2_lo [3];
  logic signed [PIW-1:0]    s2_hi [3];
  logic [SOLID_W-1:0]       s2_solid;
  logic [DIST_W-1:0]        s2_d [6];
  logic                     s2_hit;

  logic [2:0]               best;
  logic signed [PIW-1:0]    p_next [3];

  // Offsets must change only while the unit is idle; the cell does not enforce it.
  assign m_s = EW'(signed'({1'b0, margin}));
  assign h_s = EW'(signed'({1'b0, height}));

  assign lo_off[0] = LO_KX - m_s;
  assign hi_off[0] = HI_KX + m_s;
  assign lo_off[1] = LO_KY - m_s;
  assign hi_off[1] = HI_KY + h_s;
  assign lo_off[2] = LO_KZ - m_s;
  assign hi_off[2] = HI_KZ + m_s;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_next[a] = up_base[a] + PIW'(lo_off[a]);
      hi_next[a] = up_base[a] + PIW'(hi_off[a]);
    end
  end

  // Inside the box exactly when every distance is non-negative.
  always_comb begin
    hit_next = s1_solid[IDX];
    for (int a = 0; a < 3; a++) begin
      dlo[a] = (PIW + 1)'(s1_p[a]) - (PIW + 1)'(s1_lo[a]);
      dhi[a] = (PIW + 1)'(s1_hi[a]) - (PIW + 1)'(s1_p[a]);
      d_next[2 * a]     = DIST_W'(dlo[a]);
      d_next[2 * a + 1] = DIST_W'(dhi[a]);
      if (dlo[a][PIW] || dhi[a][PIW]) begin
        hit_next = 1'b0;
      end
    end
  end

  // Nearest face, first one wins on a tie.
  always_comb begin
    logic [DIST_W-1:0] best_d;
    best_d = s2_d[0];
    best   = 3'd0;
    for (int i = 1; i < 6; i++) begin
      if (s2_d[i] < best_d) begin
        best_d = s2_d[i];
        best   = 3'(i);
      end
    end
    p_next = s2_p;
    if (s2_hit) begin
      p_next[best[2:1]] = best[0] ? s2_hi[best[2:1]] : s2_lo[best[2:1]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      dn_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= up_vld;
      s2_vld <= s1_vld;
      dn_vld <= s2_vld;
    end
    if (en) begin
      s1_p     <= up_p;
      s1_base  <= up_base;
      s1_lo    <= lo_next;
      s1_hi    <= hi_next;
      s1_solid <= up_solid;
      s2_p     <= s1_p;
      s2_base  <= s1_base;
      s2_lo    <= s1_lo;
      s2_hi    <= s1_hi;
      s2_solid <= s1_solid;
      s2_d     <= d_next;
      s2_hit   <= hit_next;
      dn_p     <= p_next;
      dn_base  <= s2_base;
      dn_solid <= s2_solid & ~(SOLID_W'(1) << IDX);
    end
  end

endmodule

// ===== design/vbp_outbuf.sv =====
// ----------------------------------------------------------------------------
// vbp_outbuf: two-entry result buffer
// Holds the result on view plus one spare, so the chain keeps moving.
// ----------------------------------------------------------------------------
module vbp_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  vbp_pkg::result_t  wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_stall,
  output vbp_pkg::result_t  rd_data
);
  import vbp_pkg::*;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_ONE,
    HOLD_TWO
  } fill_t;

  fill_t   fill;
  result_t spare;
  logic    pop;

  assign rd_valid = (fill != HOLD_NONE);
  assign full     = (fill == HOLD_TWO);
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= HOLD_NONE;
    end else begin
      case (fill)
        HOLD_NONE: begin
          if (wr) begin
            rd_data <= wr_data;
            fill    <= HOLD_ONE;
          end
        end
        HOLD_ONE: begin
          if (wr && pop) begin
            rd_data <= wr_data;
          end else if (wr) begin
            spare <= wr_data;
            fill  <= HOLD_TWO;
          end else if (pop) begin
            fill <= HOLD_NONE;
          end
        end
        HOLD_TWO: begin
          if (pop) begin
            rd_data <= spare;
            fill    <= HOLD_ONE;
          end
        end
        default: begin
          fill <= HOLD_NONE;
        end
      endcase
    end
  end

endmodule

// ===== design/voxel_box_pushout_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_box_pushout_unit: push a body out of its 3x3x3 solid voxel neighbours
// Throughput: one body per cycle while the result buffer is not full;
// 27 voxel cells of three stages each in a row.
// Reset: clears pipeline valids and result buffer; registers take defaults.
// ----------------------------------------------------------------------------
module voxel_box_pushout_unit #(
  parameter int FRAC_BITS = vbp_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // body channel
  input  logic                              body_valid,
  output logic                              body_stall,
  input  vbp_pkg::body_t                    body,
  // result channel
  output logic                              result_valid,
  input  logic                              result_stall,
  output vbp_pkg::result_t                  result,
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vbp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vbp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import vbp_pkg::*;

  localparam int PIW   = pos_int_w(FRAC_BITS);
  localparam int NCELL = SOLID_W;

  localparam logic signed [PIW-1:0] SAT_HI = PIW'({1'b0, {(POS_W - 1){1'b1}}});
  localparam logic signed [PIW-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  logic [MARGIN_W-1:0]    edge_margin;
  logic [HEIGHT_W-1:0]    body_height;

  // Pipeline control: one enable for the whole chain.
  logic                   en;
  logic                   buf_full;
  logic                   accept;

  // Chain between cells; entry 0 is the input stage, entry NCELL the last cell.
  logic                   chain_vld   [NCELL+1];
  logic signed [PIW-1:0]  chain_p     [NCELL+1][3];
  logic signed [PIW-1:0]  chain_base  [NCELL+1][3];
  logic [SOLID_W-1:0]     chain_solid [NCELL+1];

  logic signed [POS_W-1:0] flr_x;
  logic signed [POS_W-1:0] flr_y;
  logic signed [POS_W-1:0] flr_z;

  logic                   sat_vld;
  result_t                sat_res;
  result_t                sat_next;

  function automatic logic signed [POS_W-1:0] clamp(input logic signed [PIW-1:0] v);
    logic signed [PIW-1:0] c;
    c = v;
    if (c > SAT_HI) begin
      c = SAT_HI;
    end
    if (c < SAT_LO) begin
      c = SAT_LO;
    end
    return c[POS_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Register port: always ready; index beyond the list is dropped.
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_margin <= MARGIN_RST;
      body_height <= HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_EDGE_MARGIN: edge_margin <= cfg_data[MARGIN_W-1:0];
        CFG_BODY_HEIGHT: body_height <= cfg_data[HEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. The chain advances every cycle unless the result buffer
  // already holds two results; only then freeze and stall the body side.
  // Bubbles travel with the chain, so nothing waits on the output otherwise.
  // --------------------------------------------------------------------------
  assign en         = !buf_full;
  assign body_stall = buf_full;
  assign accept     = body_valid && en;

  // --------------------------------------------------------------------------
  // Entry stage: widen the position and floor it once to the cell base
  // (clear the fraction bits, arithmetic floor in two's complement).
  // The base stays fixed for the body while its position is pushed about.
  // --------------------------------------------------------------------------
  assign flr_x = {body.pos_x[POS_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
  assign flr_y = {body.pos_y[POS_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
  assign flr_z = {body.pos_z[POS_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_vld[0] <= 1'b0;
    end else if (en) begin
      chain_vld[0] <= body_valid;
    end
    if (accept) begin
      chain_p[0][0]    <= PIW'(body.pos_x);
      chain_p[0][1]    <= PIW'(body.pos_y);
      chain_p[0][2]    <= PIW'(body.pos_z);
      chain_base[0][0] <= PIW'(flr_x);
      chain_base[0][1] <= PIW'(flr_y);
      chain_base[0][2] <= PIW'(flr_z);
      chain_solid[0]   <= body.neighbor_solid;
    end
  end

  // --------------------------------------------------------------------------
  // Voxel cells in visiting order: x outermost, z innermost, which is also
  // ascending mask bit order. Each cell consumes its own mask bit.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    vbp_cell #(
      .FRAC_BITS (FRAC_BITS),
      .DX        (k / 9),
      .DY        ((k / 3) % 3),
      .DZ        (k % 3)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .margin   (edge_margin),
      .height   (body_height),
      .up_vld   (chain_vld[k]),
      .up_p     (chain_p[k]),
      .up_base  (chain_base[k]),
      .up_solid (chain_solid[k]),
      .dn_vld   (chain_vld[k+1]),
      .dn_p     (chain_p[k+1]),
      .dn_base  (chain_base[k+1]),
      .dn_solid (chain_solid[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Saturation stage: clamp each coordinate to the signed output range.
  // --------------------------------------------------------------------------
  always_comb begin
    sat_next.new_x = clamp(chain_p[NCELL][0]);
    sat_next.new_y = clamp(chain_p[NCELL][1]);
    sat_next.new_z = clamp(chain_p[NCELL][2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_vld <= 1'b0;
    end else if (en) begin
      sat_vld <= chain_vld[NCELL];
    end
    if (en) begin
      sat_res <= sat_next;
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: the result on view plus one spare transfer.
  // --------------------------------------------------------------------------
  vbp_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .wr       (sat_vld && en),
    .wr_data  (sat_res),
    .full     (buf_full),
    .rd_valid (result_valid),
    .rd_stall (result_stall),
    .rd_data  (result)
  );

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  // A full buffer must hold off the body side.
  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    buf_full |-> body_stall)
    else $error("body accepted while result buffer full");

  // A frozen chain keeps its last result in place.
  a_freeze_holds: assert property (@(posedge clk) disable iff (rst)
    (!en && sat_vld) |=> (sat_vld && $stable(sat_res)))
    else $error("saturation stage changed while chain frozen");

  // Every cell has consumed its mask bit by the end of the chain.
  a_mask_consumed: assert property (@(posedge clk) disable iff (rst)
    chain_vld[NCELL] |-> (chain_solid[NCELL] == '0))
    else $error("solid mask bits left after last cell");

  // The cell base is still aligned to whole voxels at the end of the chain.
  a_base_aligned: assert property (@(posedge clk) disable iff (rst)
    chain_vld[NCELL] |-> ((chain_base[NCELL][0][FRAC_BITS-1:0] == '0)
      && (chain_base[NCELL][1][FRAC_BITS-1:0] == '0)
      && (chain_base[NCELL][2][FRAC_BITS-1:0] == '0)))
    else $error("cell base lost voxel alignment");

endmodule

// ===== verif/vbp_pushout_monitor.sv =====
// ----------------------------------------------------------------------------
// vbp_pushout_monitor: push-out prediction and result comparison
// Watches the body, result and register channels of the push-out unit,
// predicts the resolved position of every accepted body and compares each
// result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module vbp_pushout_monitor (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           body_valid,
  input  logic                           body_stall,
  input  vbp_pkg::body_t                 body,
  input  logic                           result_valid,
  input  logic                           result_stall,
  input  vbp_pkg::result_t               result,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [vbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vbp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import vbp_pkg::*;

  localparam longint POS_MAX = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;

  logic [MARGIN_W-1:0] margin_q;
  logic [HEIGHT_W-1:0] height_q;
  result_t             expected_positions [$];

  // Resolve one body against its solid neighbours, full precision between cells.
  function automatic result_t resolve_position(input body_t b,
                                               input logic [MARGIN_W-1:0] mg,
                                               input logic [HEIGHT_W-1:0] ht);
    longint  p [3];
    longint  base [3];
    longint  lo [3];
    longint  hi [3];
    longint  gap [6];
    longint  one;
    longint  mgn;
    longint  hgt;
    bit      hit;
    int      best;
    result_t r;
    one = longint'(1) << FRAC_BITS_DEF;
    mgn = longint'(mg);
    hgt = longint'(ht);
    p[0] = $signed(b.pos_x);
    p[1] = $signed(b.pos_y);
    p[2] = $signed(b.pos_z);
    for (int a = 0; a < 3; a++) base[a] = p[a] >>> FRAC_BITS_DEF;
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dz = 0; dz < 3; dz++) begin
          if (b.neighbor_solid[9*dx + 3*dy + dz]) begin
            lo[0] = (base[0] + dx - 1) * one - mgn;
            hi[0] = (base[0] + dx - 1) * one + one + mgn;
            lo[1] = (base[1] + dy - 2) * one - mgn;
            hi[1] = (base[1] + dy - 2) * one + one + hgt;
            lo[2] = (base[2] + dz - 1) * one - mgn;
            hi[2] = (base[2] + dz - 1) * one + one + mgn;
            hit = 1'b1;
            for (int a = 0; a < 3; a++)
              if (p[a] < lo[a] || p[a] > hi[a]) hit = 1'b0;
            if (hit) begin
              for (int a = 0; a < 3; a++) begin
                gap[2*a]     = p[a] - lo[a];
                gap[2*a + 1] = hi[a] - p[a];
              end
              // first face wins on equal distance
              best = 0;
              for (int f = 1; f < 6; f++)
                if (gap[f] < gap[best]) best = f;
              p[best/2] = (best % 2) ? hi[best/2] : lo[best/2];
            end
          end
        end
      end
    end
    for (int a = 0; a < 3; a++) begin
      if (p[a] > POS_MAX) p[a] = POS_MAX;
      if (p[a] < POS_MIN) p[a] = POS_MIN;
    end
    r.new_x = POS_W'(p[0]);
    r.new_y = POS_W'(p[1]);
    r.new_z = POS_W'(p[2]);
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [POS_W-1:0] want,
                             input logic signed [POS_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      margin_q = MARGIN_RST;
      height_q = HEIGHT_RST;
      expected_positions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_EDGE_MARGIN: margin_q = cfg_data[MARGIN_W-1:0];
          CFG_BODY_HEIGHT: height_q = cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (body_valid && !body_stall)
        expected_positions.push_back(resolve_position(body, margin_q, height_q));
      if (result_valid && !result_stall) begin
        if (expected_positions.size() == 0) begin
          $error("result transfer with no body outstanding: %0d %0d %0d",
                 result.new_x, result.new_y, result.new_z);
          fail_count++;
        end else begin
          want = expected_positions.pop_front();
          check_field("new_x", want.new_x, result.new_x);
          check_field("new_y", want.new_y, result.new_y);
          check_field("new_z", want.new_z, result.new_z);
        end
      end
    end
  end

endmodule

// ===== verif/tb_voxel_box_pushout_unit.sv =====
// ----------------------------------------------------------------------------
// tb_voxel_box_pushout_unit: testbench for the voxel box push-out unit
// Drives bodies and register writes, stalls the result side in several
// patterns and leaves prediction and comparison to the monitor beside the
// block. Prints the verdict once every body has been resolved.
// ----------------------------------------------------------------------------
module tb_voxel_box_pushout_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vbp_pkg::*;

  localparam int RAND_PER_PHASE = 155;
  localparam int FILL_ITEMS     = 200;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 120;   // beyond the push-out latency
  localparam int QUIET_LIMIT    = 5000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  body_valid;
  logic                  body_stall;
  body_t                 body;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int bodies_in;
  int results_out;
  int quiet_cycles;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  voxel_box_pushout_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .body_valid   (body_valid),
    .body_stall   (body_stall),
    .body         (body),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  vbp_pushout_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .body_valid   (body_valid),
    .body_stall   (body_stall),
    .body         (body),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count)
  );

  // Count transfers on both data channels and watch for a hung block: any
  // transfer on any channel clears the quiet counter.
  always @(posedge clk) begin
    if (rst) begin
      bodies_in    <= 0;
      results_out  <= 0;
      quiet_cycles <= 0;
    end else begin
      if (body_valid && !body_stall) bodies_in <= bodies_in + 1;
      if (result_valid && !result_stall) results_out <= results_out + 1;
      if ((body_valid && !body_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Result side: random stall at the current rate, or one long hold-off when
  // asked, counted here so that the block fills and pushes back on bodies.
  initial begin : result_sink
    int  held;
    bit  hold_served;
    held = 0;
    hold_served = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        result_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) hold_served = 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // One coordinate: mostly near the origin, sometimes at either end of the
  // range so that push-out runs into saturation. Fractions favour the
  // interesting spots: cell edges, centre and the default margin.
  function automatic logic [POS_W-1:0] near_coord();
    logic [15:0] whole;
    logic [15:0] frac;
    case ($urandom_range(9))
      0:       whole = 16'h7FFF - 16'($urandom_range(1));
      1:       whole = 16'h8000 + 16'($urandom_range(1));
      default: whole = 16'(int'($urandom_range(6)) - 3);
    endcase
    case ($urandom_range(7))
      0:       frac = 16'h0000;
      1:       frac = 16'h8000;
      2:       frac = 16'hFFFF;
      3:       frac = 16'(19661);
      4:       frac = 16'(65536 - 19661);
      default: frac = 16'($urandom);
    endcase
    return {whole, frac};
  endfunction

  function automatic body_t random_body();
    body_t b;
    if ($urandom_range(99) < 10) begin
      b.pos_x = $urandom;
      b.pos_y = $urandom;
      b.pos_z = $urandom;
    end else begin
      b.pos_x = near_coord();
      b.pos_y = near_coord();
      b.pos_z = near_coord();
    end
    case ($urandom_range(5))
      0:       b.neighbor_solid = '1;
      1:       b.neighbor_solid = SOLID_W'($urandom & $urandom);
      2:       b.neighbor_solid = SOLID_W'($urandom | $urandom);
      3:       b.neighbor_solid = SOLID_W'(1) << $urandom_range(SOLID_W - 1);
      default: b.neighbor_solid = SOLID_W'($urandom);
    endcase
    return b;
  endfunction

  // Offer one body, idling beforehand at the sender's rate; return at the
  // edge of its transfer with valid still high.
  task automatic push_body(input body_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      body_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    body       <= b;
    body_valid <= 1'b1;
    do @(posedge clk); while (body_stall);
  endtask

  task automatic push_fields(input logic [POS_W-1:0] x, y, z,
                             input logic [SOLID_W-1:0] solid);
    body_t b;
    b.pos_x = x;
    b.pos_y = y;
    b.pos_z = z;
    b.neighbor_solid = solid;
    push_body(b);
  endtask

  // Drop valid and hold until every body has come back out.
  task automatic wait_for_results();
    body_valid <= 1'b0;
    @(posedge clk);
    while (results_out != bodies_in) @(posedge clk);
  endtask

  // Write both registers back to back; valid stays high across the pair.
  task automatic set_registers(input logic [CFG_DATA_W-1:0] margin, height);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_EDGE_MARGIN;
    cfg_data  <= margin;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_BODY_HEIGHT;
    cfg_data  <= height;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst           <= 1'b1;
    body_valid    <= 1'b0;
    body          <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_EDGE_MARGIN;
    cfg_data      <= '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed bodies under the reset register values, no idling.
    push_fields('0, '0, '0, '0);
    push_fields('0, '0, '0, '1);
    push_fields(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
    push_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
    push_fields(32'h7FFF_8000, 32'h0000_8000, 32'h8000_4000, '1);
    push_fields(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 27'h2AA_AAAA);
    push_fields(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 27'h555_5555);
    // centred in the cell: every face but +y sits at equal depth, so -x must win
    push_fields(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 27'(1) << 16);
    // on the lower x face of the next voxel up in x exactly, bounds are inclusive
    push_fields(32'(-19661), 32'h0000_8000, 32'h0000_8000, 27'(1) << 25);
    for (int i = 0; i < SOLID_W; i += 2)
      push_fields(32'h0000_8000, 32'h0000_4000, 32'hFFFF_C000, 27'(1) << i);

    // Random phases: new register settings each time, idling rotating
    // through none, sender only, receiver only and both at a light rate.
    for (int ph = 1; ph <= 8; ph++) begin
      wait_for_results();
      case (ph)
        1:       set_registers('0, '0);
        2:       set_registers(32'd65536, 32'd262144);
        3:       set_registers('1, '1);
        8:       set_registers(CFG_DATA_W'(MARGIN_RST), CFG_DATA_W'(HEIGHT_RST));
        default: begin
          if ($urandom_range(3) == 0) set_registers($urandom, $urandom);
          else set_registers($urandom_range(65536), $urandom_range(262144));
        end
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 88; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 88; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (RAND_PER_PHASE) push_body(random_body());
    end

    // Fill the pipeline against a long receiver hold-off while bodies keep
    // coming, so the block has to stall its input.
    wait_for_results();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b1;
    repeat (FILL_ITEMS) push_body(random_body());

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
